>>> sv/rmsv_pkg.sv
// Shared constants and helpers for the windowed RMS voltmeter.
`timescale 1ns / 1ps

package rmsv_pkg;

   localparam int DEF_MAX_WINDOW  = 1024;
   localparam int DEF_SAMPLE_BITS = 12;

   // register file
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FULL_SCALE_MV = 2'd1;

   localparam int WIN_CFG_W = 11;
   localparam int FS_W      = 16;
   localparam int MV_W      = 16;

   localparam logic [WIN_CFG_W-1:0] WIN_RESET = 11'd100;
   localparam logic [FS_W-1:0]      FS_RESET  = 16'd18000;

   function automatic int max_int(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

endpackage

>>> sv/rmsv_mul.sv
// Shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps

module rmsv_mul #(
   parameter int A_W = 16,
   parameter int B_W = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [A_W-1:0]     op_a,
   input  logic [B_W-1:0]     op_b,
   output logic               busy,
   output logic               done,
   output logic [A_W+B_W-1:0] product
);

   localparam int P_W   = A_W + B_W;
   localparam int CNT_W = $clog2(A_W);

   logic [P_W-1:0]   acc_ff, acc_in;
   logic [B_W-1:0]   mcand_ff, mcand_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [B_W:0]     upper;

   // upper half accumulates, lower half shifts the multiplier out
   assign upper = {1'b0, acc_ff[P_W-1:A_W]} + ((acc_ff[0]) ? {1'b0, mcand_ff} : '0);

   always_comb begin
      acc_in   = acc_ff;
      mcand_in = mcand_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         acc_in   = {{B_W{1'b0}}, op_a};
         mcand_in = op_b;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         acc_in = {upper, acc_ff[A_W-1:1]};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(A_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
      cnt_ff   <= cnt_in;
   end

   assign busy    = busy_ff;
   assign done    = done_ff;
   assign product = acc_ff;

endmodule

>>> sv/rmsv_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module rmsv_div #(
   parameter int N_W = 34,
   parameter int D_W = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [N_W-1:0] dividend,
   input  logic [D_W-1:0] divisor,
   output logic           busy,
   output logic           done,
   output logic [N_W-1:0] quotient
);

   localparam int CNT_W = $clog2(N_W);

   logic [D_W-1:0]   rem_ff, rem_in;
   logic [N_W-1:0]   quo_ff, quo_in;
   logic [D_W-1:0]   dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [D_W:0]     shifted, diff;
   logic             ge;

   assign shifted = {rem_ff, quo_ff[N_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign ge      = (shifted >= {1'b0, dvs_ff});

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[D_W-1:0] : shifted[D_W-1:0];
         quo_in = {quo_ff[N_W-2:0], ge};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(N_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> sv/rmsv_isqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
`timescale 1ns / 1ps

module rmsv_isqrt #(
   parameter int R_W = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [2*R_W-1:0] radicand,
   output logic             busy,
   output logic             done,
   output logic [R_W-1:0]   root
);

   localparam int CNT_W = $clog2(R_W);

   logic [2*R_W-1:0] rad_ff, rad_in;
   logic [R_W:0]     rem_ff, rem_in;
   logic [R_W-1:0]   root_ff, root_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [R_W+2:0]   rem_sh, trial, diff;
   logic             ge;

   // bring down two radicand bits, try root*4+1
   assign rem_sh = {rem_ff, rad_ff[2*R_W-1 -: 2]};
   assign trial  = (R_W + 3)'({root_ff, 2'b01});
   assign diff   = rem_sh - trial;
   assign ge     = (rem_sh >= trial);

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[2*R_W-3:0], 2'b00};
         rem_in  = ge ? diff[R_W:0] : rem_sh[R_W:0];
         root_in = {root_ff[R_W-2:0], ge};
         cnt_in  = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(R_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign root = root_ff;

endmodule

>>> sv/windowed_rms_voltmeter.sv
// Windowed RMS voltmeter top level: sequencer, accumulator and result register.
//
//   port group | dir | handshake            | payload
//   req_       | in  | req_valid/req_stall  | req_sample
//   rsp_       | out | rsp_valid/rsp_stall  | rsp_mean_square, rsp_rms_code_q4,
//              |     |                      | rsp_rms_millivolts
//   csr_       | in  | csr_valid/csr_ready  | csr_index, csr_wdata
//
// Each sample is squared by the bit-serial multiplier; req_stall holds off the next sample
// until the sequencer is idle again. The last sample of a window adds a mean divide,
// square root, scale multiply and scale divide.
// Reset is synchronous; it clears the sum, the count and the result valid flag and
// loads the registers with their reset values; no clearing pass is needed. A stalled
// result word is held in the output register while the next samples are accepted.
`timescale 1ns / 1ps

module windowed_rms_voltmeter #(
   parameter int MAX_WINDOW  = rmsv_pkg::DEF_MAX_WINDOW,
   parameter int SAMPLE_BITS = rmsv_pkg::DEF_SAMPLE_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [SAMPLE_BITS-1:0]           req_sample,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [2*SAMPLE_BITS-1:0]         rsp_mean_square,
   output logic [SAMPLE_BITS+3:0]           rsp_rms_code_q4,
   output logic [rmsv_pkg::MV_W-1:0]        rsp_rms_millivolts,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rmsv_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rmsv_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import rmsv_pkg::*;

   localparam int Q_W     = SAMPLE_BITS + 4;
   localparam int MS_W    = 2 * SAMPLE_BITS;
   localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
   localparam int CNTR_W  = $clog2(MAX_WINDOW);
   localparam int SUM_W   = MS_W + CNTR_W;
   localparam int PROD_W  = Q_W + FS_W;
   localparam int DIV_N_W = max_int(SUM_W, PROD_W);
   localparam int DIV_D_W = max_int(CNT_W, Q_W);
   localparam int WCMP_W  = max_int(WIN_CFG_W, CNT_W);
   localparam logic [Q_W-1:0] Q4_FULL = Q_W'(((1 << SAMPLE_BITS) - 1) * 16);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SQ    = 3'd1;
   localparam logic [2:0] S_MEAN  = 3'd2;
   localparam logic [2:0] S_ROOT  = 3'd3;
   localparam logic [2:0] S_SCALE = 3'd4;
   localparam logic [2:0] S_MVDIV = 3'd5;
   localparam logic [2:0] S_SEND  = 3'd6;

   logic [2:0]           state_ff, state_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [CNTR_W-1:0]    count_ff, count_in;
   logic [WIN_CFG_W-1:0] win_cfg_ff, win_cfg_in;
   logic [FS_W-1:0]      fs_ff, fs_in;
   logic [MS_W-1:0]      mean_ff, mean_in;
   logic [Q_W-1:0]       q4_ff, q4_in;
   logic [MV_W-1:0]      mv_ff, mv_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [MS_W-1:0]      out_ms_ff, out_ms_in;
   logic [Q_W-1:0]       out_q4_ff, out_q4_in;
   logic [MV_W-1:0]      out_mv_ff, out_mv_in;

   logic                 mul_start, mul_busy, mul_done;
   logic [Q_W-1:0]       mul_a;
   logic [FS_W-1:0]      mul_b;
   logic [PROD_W-1:0]    mul_prod;
   logic                 div_start, div_busy, div_done;
   logic [DIV_N_W-1:0]   div_n, div_q;
   logic [DIV_D_W-1:0]   div_d;
   logic                 root_start, root_busy, root_done;
   logic [Q_W-1:0]       root_q;

   logic [SUM_W-1:0]     sum_new;
   logic [CNT_W-1:0]     n_cur;
   logic [WCMP_W-1:0]    win_ext, eff_win;
   logic                 win_last;

   assign sum_new = sum_ff + SUM_W'(mul_prod[MS_W-1:0]);
   assign n_cur   = CNT_W'(count_ff) + CNT_W'(1);
   assign win_ext = WCMP_W'(win_cfg_ff);

   // zero length acts as one, long windows clamp to the maximum
   always_comb begin
      if (win_ext == '0) begin
         eff_win = WCMP_W'(1);
      end else if (win_ext > WCMP_W'(MAX_WINDOW)) begin
         eff_win = WCMP_W'(MAX_WINDOW);
      end else begin
         eff_win = win_ext;
      end
   end

   assign win_last = (WCMP_W'(n_cur) >= eff_win);

   // shared units: squarer doubles as the millivolt scaler, one divider for both quotients
   assign mul_a = (state_ff == S_ROOT) ? root_q : Q_W'(req_sample);
   assign mul_b = (state_ff == S_ROOT) ? fs_ff : FS_W'(req_sample);
   assign div_n = (state_ff == S_SQ) ? DIV_N_W'(sum_new) : DIV_N_W'(mul_prod);
   assign div_d = (state_ff == S_SQ) ? DIV_D_W'(n_cur) : DIV_D_W'(Q4_FULL);

   rmsv_mul #(.A_W(Q_W), .B_W(FS_W)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .busy    (mul_busy),
      .done    (mul_done),
      .product (mul_prod)
   );

   rmsv_div #(.N_W(DIV_N_W), .D_W(DIV_D_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_n),
      .divisor  (div_d),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_q)
   );

   rmsv_isqrt #(.R_W(Q_W)) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand ({div_q[MS_W-1:0], 8'h00}),
      .busy     (root_busy),
      .done     (root_done),
      .root     (root_q)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      win_cfg_in = win_cfg_ff;
      fs_in      = fs_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_WINDOW_LENGTH: win_cfg_in = csr_wdata[WIN_CFG_W-1:0];
            REG_FULL_SCALE_MV: fs_in = csr_wdata[FS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      mean_in      = mean_ff;
      q4_in        = q4_ff;
      mv_in        = mv_ff;
      out_ms_in    = out_ms_ff;
      out_q4_in    = out_q4_ff;
      out_mv_in    = out_mv_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mul_start    = 1'b0;
      div_start    = 1'b0;
      root_start   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               mul_start = 1'b1;
               state_in  = S_SQ;
            end
         end
         S_SQ: begin
            if (mul_done) begin
               if (win_last) begin
                  // divider holds its own copy of the sum
                  div_start = 1'b1;
                  sum_in    = '0;
                  count_in  = '0;
                  state_in  = S_MEAN;
               end else begin
                  sum_in   = sum_new;
                  count_in = n_cur[CNTR_W-1:0];
                  state_in = S_IDLE;
               end
            end
         end
         S_MEAN: begin
            if (div_done) begin
               mean_in    = div_q[MS_W-1:0];
               root_start = 1'b1;
               state_in   = S_ROOT;
            end
         end
         S_ROOT: begin
            if (root_done) begin
               q4_in     = root_q;
               mul_start = 1'b1;
               state_in  = S_SCALE;
            end
         end
         S_SCALE: begin
            if (mul_done) begin
               div_start = 1'b1;
               state_in  = S_MVDIV;
            end
         end
         S_MVDIV: begin
            if (div_done) begin
               mv_in    = (|div_q[DIV_N_W-1:MV_W]) ? {MV_W{1'b1}} : div_q[MV_W-1:0];
               state_in = S_SEND;
            end
         end
         S_SEND: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               out_ms_in    = mean_ff;
               out_q4_in    = q4_ff;
               out_mv_in    = mv_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         win_cfg_ff   <= WIN_RESET;
         fs_ff        <= FS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         win_cfg_ff   <= win_cfg_in;
         fs_ff        <= fs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mean_ff   <= mean_in;
      q4_ff     <= q4_in;
      mv_ff     <= mv_in;
      out_ms_ff <= out_ms_in;
      out_q4_ff <= out_q4_in;
      out_mv_ff <= out_mv_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_mean_square    = out_ms_ff;
   assign rsp_rms_code_q4    = out_q4_ff;
   assign rsp_rms_millivolts = out_mv_ff;

   a_rsp_from_send: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_SEND)
      else $error("result word raised outside the send step");

   a_q4_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> out_q4_ff <= Q4_FULL)
      else $error("root above full-scale code");

   a_window_cleared: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MEAN |-> sum_ff == '0 && count_ff == '0)
      else $error("sum or count not cleared at window end");

   a_mul_free: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> !mul_busy)
      else $error("multiplier restarted while busy");

   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy && !root_busy)
      else $error("divider restarted while a unit is busy");

endmodule
